### sv/wppd_pkg.sv
// Package for the window product block: field widths, operation codes and
// the sequencer state type. No dependencies.
package wppd_pkg;

    localparam int PREFIX_W = 32;
    localparam int VALUE_W  = 7;
    localparam int COUNT_W  = 10;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### sv/wppd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wppd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/wppd_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on wppd_pkg for the operand width.
module wppd_div
    import wppd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PREFIX_W-1:0] dividend,
    input  logic [PREFIX_W-1:0] divisor,
    output logic                done,
    output logic [PREFIX_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PREFIX_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PREFIX_W-1:0] rem_reg;
    logic [PREFIX_W-1:0] quot_reg;
    logic [PREFIX_W-1:0] dvs_reg;

    logic [PREFIX_W:0]   rem_shift;
    logic                ge;
    logic [PREFIX_W-1:0] rem_next;
    logic [PREFIX_W-1:0] quot_next;

    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[PREFIX_W-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        rem_next  = ge ? PREFIX_W'(rem_shift - {1'b0, dvs_reg}) : PREFIX_W'(rem_shift);
        quot_next = {quot_reg[PREFIX_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PREFIX_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The quotient shifts in from the low end as the dividend shifts out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### sv/window_product_prefix_divide.sv
// Top level of the window product block: sequencer, run state, prefix ring
// and output register. Depends on wppd_pkg, wppd_ram and wppd_div.
//
// Usage: input transfers arrive on the s_ group. s_tuser selects the
// operation (0 append, 1 query); s_tdata carries value and count. An append
// yields no result and leaves s_tready high, so appends may follow each
// other back to back. A query yields one result on the m_ group: m_tdata is
// the product of the last count values and m_tuser the sticky overflow flag.
// A query that needs a stored prefix reads the ring and then, unless that
// prefix is zero (result zero), runs the radix-2 divider, one quotient bit a
// cycle; s_tready stays low from acceptance until the result is registered. A
// query answered without division (window reaches the run start, or beyond
// it) goes straight to the final state. The output register holds a finished
// result while the receiver stalls; appends are still taken then, and a
// following query waits in its final state until the register is free.
// Reset clears the run length, write pointer, overflow flag and the output
// valid; the ring itself needs no clearing because the run length keeps
// unwritten entries from being read.
module window_product_prefix_divide
    import wppd_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // value [6:0], count [16:7], zero fill
    input  logic [0:0]  s_tuser,   // func [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // product [31:0]
    output logic [0:0]  m_tuser    // overflow [0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int RW = $clog2(DEPTH + 2);
    localparam int CW = (RW > COUNT_W) ? RW : COUNT_W;
    localparam int MW = PREFIX_W + VALUE_W;

    state_t state_reg, state_next;

    logic [AW-1:0]       wp_reg, wp_next;
    logic [RW-1:0]       run_reg, run_next;
    logic                ovf_reg, ovf_next;
    logic [PREFIX_W-1:0] newest_reg, newest_next;
    logic [PREFIX_W-1:0] result_reg, result_next;
    logic                out_valid_reg, out_valid_next;
    logic [PREFIX_W-1:0] out_product_reg, out_product_next;
    logic                out_ovf_reg, out_ovf_next;

    logic                in_func;
    logic [VALUE_W-1:0]  in_value;
    logic [COUNT_W-1:0]  in_count;
    logic                accept;

    logic [CW-1:0]       cnt_w;
    logic [CW-1:0]       run_w;
    logic                hit_one;
    logic                hit_ring;
    logic [AW:0]         idx_sum;
    logic [AW-1:0]       rd_idx;
    logic [MW-1:0]       prod_full;
    logic [PREFIX_W-1:0] prod_sat;
    logic                prod_big;

    logic                ram_we;
    logic                ram_re;
    logic [PREFIX_W-1:0] ram_rdata;
    logic                div_start;
    logic                div_done;
    logic [PREFIX_W-1:0] div_quot;

    assign in_func  = s_tuser[0];
    assign in_value = s_tdata[6:0];
    assign in_count = s_tdata[16:7];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cnt_w    = CW'(in_count);
        run_w    = CW'(run_reg);
        hit_one  = (cnt_w == run_w) && (run_w <= CW'(DEPTH));
        hit_ring = !hit_one && (cnt_w < run_w) && (cnt_w < CW'(DEPTH));
        // Slot count places behind the newest entry; the sum stays below twice
        // the depth, so one conditional subtract wraps it.
        idx_sum  = (AW + 1)'(wp_reg) + (AW + 1)'(DEPTH - 1) - (AW + 1)'(in_count);
        rd_idx   = (idx_sum >= (AW + 1)'(DEPTH)) ? AW'(idx_sum - (AW + 1)'(DEPTH))
                                                 : AW'(idx_sum);
        prod_full = MW'(newest_reg) * MW'(in_value);
        prod_big  = prod_full[MW-1:PREFIX_W] != '0;
        prod_sat  = prod_big ? '1 : prod_full[PREFIX_W-1:0];
    end

    wppd_ram #(
        .WIDTH(PREFIX_W),
        .DEPTH(DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wp_reg),
        .wdata(prod_sat),
        .re   (ram_re),
        .raddr(rd_idx),
        .rdata(ram_rdata)
    );

    wppd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(newest_reg),
        .divisor (ram_rdata),
        .done    (div_done),
        .quotient(div_quot)
    );

    always_comb
    begin
        state_next       = state_reg;
        wp_next          = wp_reg;
        run_next         = run_reg;
        ovf_next         = ovf_reg;
        newest_next      = newest_reg;
        result_next      = result_reg;
        out_valid_next   = out_valid_reg;
        out_product_next = out_product_reg;
        out_ovf_next     = out_ovf_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        div_start        = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == FUNC_APPEND)
                    begin
                        if (in_value == '0)
                        begin
                            run_next    = '0;
                            ovf_next    = 1'b0;
                            newest_next = PREFIX_W'(1);
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            newest_next = prod_sat;
                            wp_next     = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                            if (prod_big)
                            begin
                                ovf_next = 1'b1;
                            end
                            if (CW'(run_reg) <= CW'(DEPTH))
                            begin
                                run_next = run_reg + 1'b1;
                            end
                        end
                    end
                    else if (hit_one)
                    begin
                        result_next = newest_reg;
                        state_next  = ST_DONE;
                    end
                    else if (hit_ring)
                    begin
                        ram_re     = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        result_next = '0;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                if (ram_rdata == '0)
                begin
                    result_next = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    result_next = div_quot;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_product_next = result_reg;
                    out_ovf_next     = ovf_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            run_reg       <= '0;
            ovf_reg       <= 1'b0;
            newest_reg    <= PREFIX_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            run_reg       <= run_next;
            ovf_reg       <= ovf_next;
            newest_reg    <= newest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg      <= result_next;
        out_product_reg <= out_product_next;
        out_ovf_reg     <= out_ovf_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_product_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule
